// File: rtl/acce_pkg.sv
package acce_pkg;

    // paddr covers register index 0 and the next word, so writes past the map are decoded
    localparam int unsigned ADDR_W = 3;

    // register indexes (paddr[2])
    localparam logic [0:0] REG_OPTIMIZE = 1'b0;

    // stream bytes
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_M     = 8'h6D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_ONE   = 8'h31;
    localparam logic [7:0] BYTE_TWO   = 8'h32;
    localparam logic [7:0] BYTE_THREE = 8'h33;
    localparam logic [7:0] BYTE_FOUR  = 8'h34;

    // byte positions of the fixed layout of one cell's run
    typedef enum logic [4:0] {
        SL_C_ESC,
        SL_C_LB,
        SL_C_BGTEN,
        SL_C_BG,
        SL_C_SEMI,
        SL_C_FGTEN,
        SL_C_FG,
        SL_C_M,
        SL_B_ESC,
        SL_B_LB,
        SL_B_TWO,
        SL_B_ONE,
        SL_B_M,
        SL_CHAR,
        SL_R_ESC,
        SL_R_LB,
        SL_R_ZERO,
        SL_R_M
    } t_slot;

    // color index remap
    function automatic logic [2:0] color_remap(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd1;
            3'd5:    r = 3'd5;
            3'd6:    r = 3'd3;
            3'd7:    r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ansi_color_cell_encoder.sv
// ANSI color cell encoder
//
// Input channel (i_valid / o_ready): one text cell per transfer: character,
// 4-bit foreground (bit 3 = high intensity), 3-bit background, end-of-line.
// Output channel (o_valid / i_ready): the terminal byte stream, one byte per
// transfer, with o_run_last set on the final byte of each cell.
// Config port (APB, pready always high): register 0 bit 0 = optimize_changes,
// reset 1; when set, color and intensity escapes go out only on change.
//
// An input transfer captures the cell into the run state; its first byte is
// then loaded into the output register (o_valid) when that register is free.
// A cell produces 1 to 17 bytes; the byte serializer sets the rate. The next
// cell is taken in the cycle its predecessor's last byte is loaded into the
// output register, so runs follow back to back with no gap.
// Reset clears the previous-cell color state, empties the output register and
// sets optimize_changes. A stalled receiver holds the output byte; the
// serializer, and the input channel during a run, wait until it is taken.
module ansi_color_cell_encoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_char_code,
    input  logic [3:0]                 i_fg_color,
    input  logic [2:0]                 i_bg_color,
    input  logic                       i_end_of_line,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // config register
    logic r_optimize;

    // previous-cell state
    logic [2:0] r_prev_fg;
    logic [2:0] r_prev_bg;
    logic       r_prev_bold;

    // current cell, captured at input transfer
    logic       r_busy;
    acce_pkg::t_slot r_slot;
    logic [7:0] r_ch;
    logic [2:0] r_fg;
    logic [2:0] r_bg;
    logic       r_bold;
    logic       r_boldesc;
    logic       r_eol;
    logic       r_short;

    // output register
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    // cell decode at the input
    logic       in_bold;
    logic [2:0] in_fg;
    logic [2:0] in_bg;
    logic       in_color;
    logic       in_boldesc;
    logic       in_short;
    acce_pkg::t_slot in_first;

    logic       out_free;
    logic       emit;
    logic       cur_last;
    logic       in_xfer;
    logic       cfg_wr;
    acce_pkg::t_slot n_slot;
    logic [7:0] n_obyte;
    logic       n_busy;

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == acce_pkg::REG_OPTIMIZE);
    assign prdata = (paddr[2] == acce_pkg::REG_OPTIMIZE) ? {31'd0, r_optimize} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_optimize <= 1'b1;
        end else if (cfg_wr) begin
            r_optimize <= pwdata[0];
        end
    end

    // decode incoming cell against previous-cell state
    always_comb begin
        in_bold    = i_fg_color[3];
        in_fg      = acce_pkg::color_remap(i_fg_color[2:0]);
        in_bg      = acce_pkg::color_remap(i_bg_color);
        in_color   = !r_optimize || (in_fg != r_prev_fg) || (in_bg != r_prev_bg);
        in_boldesc = !r_optimize || (in_bold != r_prev_bold);
        in_short   = i_end_of_line && in_color && in_boldesc && !in_bold;
        if (in_color) begin
            in_first = acce_pkg::SL_C_ESC;
        end else if (in_boldesc) begin
            in_first = acce_pkg::SL_B_ESC;
        end else begin
            in_first = acce_pkg::SL_CHAR;
        end
    end

    // handshake
    assign out_free = !r_ovalid || i_ready;
    assign emit     = r_busy && out_free;
    assign cur_last = (r_slot == acce_pkg::SL_R_M) || ((r_slot == acce_pkg::SL_CHAR) && !r_eol);
    assign o_ready  = !r_busy || (emit && cur_last);
    assign in_xfer  = i_valid && o_ready;

    // next position in the run, skipping absent parts
    always_comb begin
        case (r_slot)
            acce_pkg::SL_C_ESC:   n_slot = acce_pkg::SL_C_LB;
            acce_pkg::SL_C_LB:    n_slot = acce_pkg::SL_C_BGTEN;
            acce_pkg::SL_C_BGTEN: n_slot = acce_pkg::SL_C_BG;
            acce_pkg::SL_C_BG:    n_slot = acce_pkg::SL_C_SEMI;
            acce_pkg::SL_C_SEMI:  n_slot = acce_pkg::SL_C_FGTEN;
            acce_pkg::SL_C_FGTEN: n_slot = acce_pkg::SL_C_FG;
            acce_pkg::SL_C_FG:    n_slot = acce_pkg::SL_C_M;
            acce_pkg::SL_C_M:     n_slot = r_boldesc ? acce_pkg::SL_B_ESC : acce_pkg::SL_CHAR;
            acce_pkg::SL_B_ESC:   n_slot = acce_pkg::SL_B_LB;
            acce_pkg::SL_B_LB:    n_slot = r_bold ? acce_pkg::SL_B_ONE : acce_pkg::SL_B_TWO;
            acce_pkg::SL_B_TWO:   n_slot = acce_pkg::SL_B_ONE;
            acce_pkg::SL_B_ONE:   n_slot = acce_pkg::SL_B_M;
            acce_pkg::SL_B_M:     n_slot = acce_pkg::SL_CHAR;
            acce_pkg::SL_CHAR:    n_slot = acce_pkg::SL_R_ESC;
            acce_pkg::SL_R_ESC:   n_slot = acce_pkg::SL_R_LB;
            acce_pkg::SL_R_LB:    n_slot = r_short ? acce_pkg::SL_R_M : acce_pkg::SL_R_ZERO;
            acce_pkg::SL_R_ZERO:  n_slot = acce_pkg::SL_R_M;
            acce_pkg::SL_R_M:     n_slot = acce_pkg::SL_R_M;
            default:              n_slot = acce_pkg::SL_CHAR;
        endcase
    end

    // byte at the current position
    always_comb begin
        case (r_slot)
            acce_pkg::SL_C_ESC:   n_obyte = acce_pkg::BYTE_ESC;
            acce_pkg::SL_C_LB:    n_obyte = acce_pkg::BYTE_LBRK;
            acce_pkg::SL_C_BGTEN: n_obyte = acce_pkg::BYTE_FOUR;
            acce_pkg::SL_C_BG:    n_obyte = acce_pkg::BYTE_ZERO + {5'd0, r_bg};
            acce_pkg::SL_C_SEMI:  n_obyte = acce_pkg::BYTE_SEMI;
            acce_pkg::SL_C_FGTEN: n_obyte = acce_pkg::BYTE_THREE;
            acce_pkg::SL_C_FG:    n_obyte = acce_pkg::BYTE_ZERO + {5'd0, r_fg};
            acce_pkg::SL_C_M:     n_obyte = acce_pkg::BYTE_M;
            acce_pkg::SL_B_ESC:   n_obyte = acce_pkg::BYTE_ESC;
            acce_pkg::SL_B_LB:    n_obyte = acce_pkg::BYTE_LBRK;
            acce_pkg::SL_B_TWO:   n_obyte = acce_pkg::BYTE_TWO;
            acce_pkg::SL_B_ONE:   n_obyte = acce_pkg::BYTE_ONE;
            acce_pkg::SL_B_M:     n_obyte = acce_pkg::BYTE_M;
            acce_pkg::SL_CHAR:    n_obyte = r_ch;
            acce_pkg::SL_R_ESC:   n_obyte = acce_pkg::BYTE_ESC;
            acce_pkg::SL_R_LB:    n_obyte = acce_pkg::BYTE_LBRK;
            acce_pkg::SL_R_ZERO:  n_obyte = acce_pkg::BYTE_ZERO;
            acce_pkg::SL_R_M:     n_obyte = acce_pkg::BYTE_M;
            default:              n_obyte = r_ch;
        endcase
    end

    // run busy flag
    always_comb begin
        if (in_xfer) begin
            n_busy = 1'b1;
        end else if (emit && cur_last) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
    end

    // control state: busy, position, previous-cell colors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= acce_pkg::SL_CHAR;
            r_prev_fg   <= 3'd0;
            r_prev_bg   <= 3'd0;
            r_prev_bold <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (in_xfer) begin
                r_slot <= in_first;
                if (i_end_of_line) begin
                    r_prev_fg   <= 3'd0;
                    r_prev_bg   <= 3'd0;
                    r_prev_bold <= 1'b0;
                end else begin
                    r_prev_fg   <= in_fg;
                    r_prev_bg   <= in_bg;
                    r_prev_bold <= in_bold;
                end
            end else if (emit) begin
                r_slot <= n_slot;
            end
        end
    end

    // cell payload capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch      <= i_char_code;
            r_fg      <= in_fg;
            r_bg      <= in_bg;
            r_bold    <= in_bold;
            r_boldesc <= in_boldesc;
            r_eol     <= i_end_of_line;
            r_short   <= in_short;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= n_obyte;
            r_olast <= cur_last;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_run_last = r_olast;

endmodule

// File: rtl/acce_checker.sv
module acce_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [7:0]                 i_char_code,
    input logic [3:0]                 i_fg_color,
    input logic [2:0]                 i_bg_color,
    input logic                       i_end_of_line,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [7:0]                 o_out_byte,
    input logic                       o_run_last,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [acce_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output byte changed");

    // a run continues without a bubble once a non-final byte is taken
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_last |=> o_valid)
        else $error("gap inside a cell's byte run");

    // input is held off only while a run is in the output register or just accepted
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid || $past(i_valid && o_ready))
        else $error("input stalled with nothing in flight");

endmodule

bind ansi_color_cell_encoder acce_checker u_acce_checker (.*);
